[rtl/prt_pkg.sv]
// Package for the point rigid transform block: widths, register indexes,
// mode codes and fixed-point helpers.
// Depends on nothing; used by point_rigid_transform and its checker.
package prt_pkg;

   // Point coordinates, signed fixed point
   localparam int COORD_BITS = 32;
   // Rotation coefficients, signed Q2.30
   localparam int COEF_BITS  = 32;
   localparam int COEF_FRAC  = 30;

   // One product and the sum or difference of two products
   localparam int PROD_W = COORD_BITS + COEF_BITS;
   localparam int SUM_W  = PROD_W + 1;
   // Width after dropping the coefficient fraction; also holds a point + offset
   localparam int WIDE_W = SUM_W - COEF_FRAC;

   localparam int DATA_W = 3 * COORD_BITS;
   localparam int TDATA_W = ((DATA_W + 7) / 8) * 8;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COS_ANGLE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIN_ANGLE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_Z  = 3'd5;
   localparam int CSR_DATA_W = (COORD_BITS > COEF_BITS) ? COORD_BITS : COEF_BITS;

   // Operating modes
   localparam logic [1:0] MODE_TRANSLATE = 2'd0;
   localparam logic [1:0] MODE_ROT_X     = 2'd1;
   localparam logic [1:0] MODE_ROT_Y     = 2'd2;
   localparam logic [1:0] MODE_ROT_Z     = 2'd3;

   localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC;
   // Half an LSB of the result, for round to nearest with ties up
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (COEF_FRAC - 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COEF_BITS-1:0]  coef_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [SUM_W-1:0]      sum_type;
   typedef logic signed [WIDE_W-1:0]     wide_type;

   // Sign-extend a coordinate to the wide width
   function automatic wide_type widen(input coord_type v);
      return {{(WIDE_W - COORD_BITS){v[COORD_BITS-1]}}, v};
   endfunction

   // Clamp a wide value into the coordinate range
   function automatic coord_type sat_coord(input wide_type v);
      logic all_same;
      all_same = (v[WIDE_W-1:COORD_BITS-1] == {(WIDE_W - COORD_BITS + 1){1'b0}}) ||
                 (v[WIDE_W-1:COORD_BITS-1] == {(WIDE_W - COORD_BITS + 1){1'b1}});
      if (all_same) begin
         return v[COORD_BITS-1:0];
      end else if (v[WIDE_W-1]) begin
         return {1'b1, {(COORD_BITS - 1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_BITS - 1){1'b1}}};
      end
   endfunction

endpackage

[rtl/point_rigid_transform.sv]
// Top level of the point rigid transform: translate or rotate one 3D point
// per transfer. Depends on prt_pkg.
//
// One point per clock while the output takes every result. Each point passes
// in order from input transfer to the output register through operand select
// and translation add, the four coefficient multiplies, the product sums with
// rounding, then scaling, saturation and axis mapping. The multiply stage sets
// the clock. Each stage moves on its own whenever the stage after it is free,
// so bubbles close up and the input keeps taking points while a result waits
// on the output side, until earlier stages fill. The user writes registers
// through the csr_ port only while no point is in flight; the block does not check.
module point_rigid_transform (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration writes
   input  logic                            csr_we,
   input  logic [prt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [prt_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // Input points
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [prt_pkg::TDATA_W-1:0]     req_tdata,   // px, py, pz
   input  logic                            req_tuser,   // last_in
   // Transformed points
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [prt_pkg::TDATA_W-1:0]     rsp_tdata,   // qx, qy, qz
   output logic                            rsp_tuser    // last_out
);
   import prt_pkg::*;

   // Configuration registers
   logic [1:0] mode_ff;
   coef_type   cos_ff, sin_ff;
   coord_type  off_x_ff, off_y_ff, off_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_TRANSLATE;
         cos_ff   <= COEF_ONE;
         sin_ff   <= '0;
         off_x_ff <= '0;
         off_y_ff <= '0;
         off_z_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_MODE:      mode_ff  <= csr_wdata[1:0];
            REG_COS_ANGLE: cos_ff   <= csr_wdata[COEF_BITS-1:0];
            REG_SIN_ANGLE: sin_ff   <= csr_wdata[COEF_BITS-1:0];
            REG_OFFSET_X:  off_x_ff <= csr_wdata[COORD_BITS-1:0];
            REG_OFFSET_Y:  off_y_ff <= csr_wdata[COORD_BITS-1:0];
            REG_OFFSET_Z:  off_z_ff <= csr_wdata[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Stage valids and per-stage advance enables
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_en, s2_en, s3_en, s4_en;

   assign s4_en      = !s4_valid_ff || rsp_tready;
   assign s3_en      = !s3_valid_ff || s4_en;
   assign s2_en      = !s2_valid_ff || s3_en;
   assign s1_en      = !s1_valid_ff || s2_en;
   assign req_tready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_en) s1_valid_ff <= req_tvalid;
         if (s2_en) s2_valid_ff <= s1_valid_ff;
         if (s3_en) s3_valid_ff <= s2_valid_ff;
         if (s4_en) s4_valid_ff <= s3_valid_ff;
      end
   end

   // Stage 1: pick the rotation plane (u, v) and axis coordinate w; add offsets
   coord_type px, py, pz;
   coord_type u_in, v_in, w_in;
   coord_type tx_in, ty_in, tz_in;

   assign px = req_tdata[COORD_BITS-1:0];
   assign py = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign pz = req_tdata[3*COORD_BITS-1:2*COORD_BITS];

   always_comb begin
      case (mode_ff)
         MODE_ROT_X: begin
            u_in = py; v_in = pz; w_in = px;
         end
         MODE_ROT_Y: begin
            u_in = pz; v_in = px; w_in = py;
         end
         MODE_ROT_Z: begin
            u_in = px; v_in = py; w_in = pz;
         end
         default: begin
            u_in = px; v_in = py; w_in = pz;
         end
      endcase
   end

   assign tx_in = sat_coord(widen(px) + widen(off_x_ff));
   assign ty_in = sat_coord(widen(py) + widen(off_y_ff));
   assign tz_in = sat_coord(widen(pz) + widen(off_z_ff));

   coord_type  s1_u_ff, s1_v_ff, s1_w_ff, s1_tx_ff, s1_ty_ff, s1_tz_ff;
   logic [1:0] s1_mode_ff;
   logic       s1_last_ff;

   always_ff @(posedge clock) begin
      if (s1_en && req_tvalid) begin
         s1_u_ff    <= u_in;
         s1_v_ff    <= v_in;
         s1_w_ff    <= w_in;
         s1_tx_ff   <= tx_in;
         s1_ty_ff   <= ty_in;
         s1_tz_ff   <= tz_in;
         s1_mode_ff <= mode_ff;
         s1_last_ff <= req_tuser;
      end
   end

   // Stage 2: the four coefficient products
   prod_type   s2_cu_ff, s2_sv_ff, s2_su_ff, s2_cv_ff;
   coord_type  s2_w_ff, s2_tx_ff, s2_ty_ff, s2_tz_ff;
   logic [1:0] s2_mode_ff;
   logic       s2_last_ff;

   always_ff @(posedge clock) begin
      if (s2_en && s1_valid_ff) begin
         s2_cu_ff   <= cos_ff * s1_u_ff;
         s2_sv_ff   <= sin_ff * s1_v_ff;
         s2_su_ff   <= sin_ff * s1_u_ff;
         s2_cv_ff   <= cos_ff * s1_v_ff;
         s2_w_ff    <= s1_w_ff;
         s2_tx_ff   <= s1_tx_ff;
         s2_ty_ff   <= s1_ty_ff;
         s2_tz_ff   <= s1_tz_ff;
         s2_mode_ff <= s1_mode_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // Stage 3: u' = c*u - s*v, v' = s*u + c*v, plus rounding half
   sum_type ru_in, rv_in;

   assign ru_in = sum_type'(s2_cu_ff) - sum_type'(s2_sv_ff) + ROUND_HALF;
   assign rv_in = sum_type'(s2_su_ff) + sum_type'(s2_cv_ff) + ROUND_HALF;

   sum_type    s3_ru_ff, s3_rv_ff;
   coord_type  s3_w_ff, s3_tx_ff, s3_ty_ff, s3_tz_ff;
   logic [1:0] s3_mode_ff;
   logic       s3_last_ff;

   always_ff @(posedge clock) begin
      if (s3_en && s2_valid_ff) begin
         s3_ru_ff   <= ru_in;
         s3_rv_ff   <= rv_in;
         s3_w_ff    <= s2_w_ff;
         s3_tx_ff   <= s2_tx_ff;
         s3_ty_ff   <= s2_ty_ff;
         s3_tz_ff   <= s2_tz_ff;
         s3_mode_ff <= s2_mode_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   // Stage 4: drop Q2.30 fraction, saturate, map to x/y/z, or take tx/ty/tz
   coord_type ou, ov;
   coord_type qx_in, qy_in, qz_in;

   assign ou = sat_coord(s3_ru_ff[SUM_W-1:COEF_FRAC]);
   assign ov = sat_coord(s3_rv_ff[SUM_W-1:COEF_FRAC]);

   always_comb begin
      case (s3_mode_ff)
         MODE_ROT_X: begin
            qx_in = s3_w_ff; qy_in = ou; qz_in = ov;
         end
         MODE_ROT_Y: begin
            qx_in = ov; qy_in = s3_w_ff; qz_in = ou;
         end
         MODE_ROT_Z: begin
            qx_in = ou; qy_in = ov; qz_in = s3_w_ff;
         end
         default: begin
            qx_in = s3_tx_ff; qy_in = s3_ty_ff; qz_in = s3_tz_ff;
         end
      endcase
   end

   coord_type s4_qx_ff, s4_qy_ff, s4_qz_ff;
   logic      s4_last_ff;

   always_ff @(posedge clock) begin
      if (s4_en && s3_valid_ff) begin
         s4_qx_ff   <= qx_in;
         s4_qy_ff   <= qy_in;
         s4_qz_ff   <= qz_in;
         s4_last_ff <= s3_last_ff;
      end
   end

   // Output channel
   assign rsp_tvalid = s4_valid_ff;
   assign rsp_tdata  = TDATA_W'({s4_qz_ff, s4_qy_ff, s4_qx_ff});
   assign rsp_tuser  = s4_last_ff;

endmodule

[rtl/point_rigid_transform_checker.sv]
// Port-level checker for point_rigid_transform, bound to the top level.
// Depends on prt_pkg.
module prt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [prt_pkg::TDATA_W-1:0]     rsp_tdata,
   input logic                            rsp_tuser
);
   import prt_pkg::*;

   // Output empties on reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result holds its payload
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Empty output register means the pipe can take a point
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

   // With the output taken throughout, an accepted point reaches the output
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tready ##1 rsp_tready ##1 rsp_tready
      ##1 rsp_tready |=> rsp_tvalid)
      else $error("result missing after pipeline latency");

endmodule

bind point_rigid_transform prt_checker u_prt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
